>>> rtl/gic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg: shared types and helpers for the greedy interval cover unit
// Range entry layout, default capacity and the sort order.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int GIC_MAX_RANGES = 64;
    localparam int GIC_COORD_W    = 16;

    typedef logic [GIC_COORD_W-1:0] gic_coord_t;

    // One stored range; lo is the start, hi the end coordinate.
    typedef struct packed {
        gic_coord_t hi;
        gic_coord_t lo;
    } gic_entry_t;

    // Sort key: ascending start, larger end first on equal starts.
    function automatic logic gic_goes_before(input gic_entry_t a, input gic_entry_t b);
        logic lt_start;
        logic eq_start;
        lt_start = (a.lo < b.lo);
        eq_start = (a.lo == b.lo);
        return lt_start || (eq_start && (a.hi > b.hi));
    endfunction

endpackage

>>> rtl/greedy_interval_cover_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_interval_cover_unit: greedy range cover selection
// Loads ranges into a sorted store, then scans it greedily on the last range
// of a set and streams out the selected ranges.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                              | tlast        | tuser
//  --------+-----+------------------------------------+--------------+-----------
//  s_*     | in  | [15:0] range_start [31:16] range_end | final_range | -
//  m_*     | out | [15:0] chosen_start [31:16] chosen_end | chosen_last | overflowed
//
//  Insertion walks the store from the top down, one entry per cycle through
//  the single read port; a range into an empty store or a dropped range is
//  handled in idle without a walk. On the last range the scan reads one entry
//  per cycle while the output takes requests, revisits an entry for each
//  tracked range that it selects, and ends with a flush.
//  s_tready is high only in idle; the scan halts while the output holds a
//  request that is not taken. Reset clears the set; the store needs no clear.
//
module greedy_interval_cover_unit import gic_pkg::*; #(
    parameter int MAX_RANGES = GIC_MAX_RANGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] range_start, [31:16] range_end
    input  logic        s_tlast,   // final_range
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] chosen_start, [31:16] chosen_end
    output logic        m_tlast,   // chosen_last
    output logic        m_tuser    // [0] overflowed
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_PUT,
        ST_SCAN_LOAD,
        ST_SCAN_FIRST,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    gic_entry_t new_reg, new_next;          // range being inserted
    logic       fin_reg, fin_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;           // insertion slot walker
    logic [CW-1:0] i_reg, i_next;           // scan index
    logic       drop_reg, drop_next;
    gic_coord_t cur_end_reg, cur_end_next;
    logic       best_valid_reg, best_valid_next;
    gic_entry_t best_reg, best_next;
    logic       pend_valid_reg, pend_valid_next;  // selected, last-ness unknown yet
    gic_entry_t pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    gic_entry_t out_reg, out_next;
    logic       out_last_reg, out_last_next;
    logic       out_ovf_reg, out_ovf_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    gic_entry_t    wr_data;
    logic [AW-1:0] rd_addr;
    gic_entry_t    rd_data;

    logic          out_free;
    logic          can_emit;
    logic          push;
    logic [CW-1:0] km1;
    logic [CW-1:0] inc_i;
    gic_entry_t    in_entry;

    gic_store #(
        .DEPTH (MAX_RANGES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_entry = gic_entry_t'(s_tdata);
    assign out_free = !out_valid_reg || m_tready;
    assign can_emit = !pend_valid_reg || out_free;
    assign km1      = k_reg - CW'(1);
    assign inc_i    = i_reg + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        new_next        = new_reg;
        fin_next        = fin_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        drop_next       = drop_reg;
        cur_end_next    = cur_end_reg;
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        out_next        = out_reg;
        push            = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = k_reg[AW-1:0];
        wr_data         = new_reg;
        rd_addr         = i_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    new_next = in_entry;
                    fin_next = s_tlast;
                    if (count_reg == CW'(MAX_RANGES))
                    begin
                        drop_next  = 1'b1;
                        state_next = s_tlast ? ST_SCAN_LOAD : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_entry;
                        count_next = CW'(1);
                        state_next = s_tlast ? ST_SCAN_LOAD : ST_IDLE;
                    end
                    else
                    begin
                        rd_addr    = AW'(count_reg - CW'(1));
                        k_next     = count_reg;
                        state_next = ST_INS;
                    end
                end
            end

            ST_INS:
            begin
                // rd_data holds entry k-1
                wr_en = 1'b1;
                if (gic_goes_before(new_reg, rd_data))
                begin
                    wr_data = rd_data;
                    k_next  = km1;
                    if (km1 == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        rd_addr = AW'(km1 - CW'(1));
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = fin_reg ? ST_SCAN_LOAD : ST_IDLE;
                end
            end

            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = fin_reg ? ST_SCAN_LOAD : ST_IDLE;
            end

            ST_SCAN_LOAD:
            begin
                rd_addr    = '0;
                state_next = ST_SCAN_FIRST;
            end

            ST_SCAN_FIRST:
            begin
                // first sorted range is always selected; pending slot is empty here
                pend_valid_next = 1'b1;
                pend_next       = rd_data;
                cur_end_next    = rd_data.hi;
                best_valid_next = 1'b0;
                i_next          = CW'(1);
                rd_addr         = AW'(CW'(1));
                state_next      = (count_reg > CW'(1)) ? ST_SCAN : ST_FINISH;
            end

            ST_SCAN:
            begin
                if (rd_data.hi <= cur_end_reg)
                begin
                    // contained in the current cover
                    i_next     = inc_i;
                    rd_addr    = inc_i[AW-1:0];
                    state_next = (inc_i == count_reg) ? ST_FINISH : ST_SCAN;
                end
                else if (rd_data.lo > cur_end_reg)
                begin
                    if (can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push          = 1'b1;
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                            out_ovf_next  = drop_reg;
                        end
                        pend_valid_next = 1'b1;
                        if (best_valid_reg)
                        begin
                            // take the tracked range, revisit this entry
                            pend_next       = best_reg;
                            cur_end_next    = best_reg.hi;
                            best_valid_next = 1'b0;
                        end
                        else
                        begin
                            pend_next    = rd_data;
                            cur_end_next = rd_data.hi;
                            i_next       = inc_i;
                            rd_addr      = inc_i[AW-1:0];
                            state_next   = (inc_i == count_reg) ? ST_FINISH : ST_SCAN;
                        end
                    end
                end
                else
                begin
                    if (!best_valid_reg || (rd_data.hi >= best_reg.hi))
                    begin
                        best_valid_next = 1'b1;
                        best_next       = rd_data;
                    end
                    i_next     = inc_i;
                    rd_addr    = inc_i[AW-1:0];
                    state_next = (inc_i == count_reg) ? ST_FINISH : ST_SCAN;
                end
            end

            ST_FINISH:
            begin
                if (best_valid_reg)
                begin
                    if (can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push          = 1'b1;
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                            out_ovf_next  = drop_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = best_reg;
                        best_valid_next = 1'b0;
                    end
                end
                else if (out_free)
                begin
                    // flush the final selection and clear the set
                    push            = pend_valid_reg;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_ovf_next    = drop_reg;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    cur_end_next    = '0;
                    drop_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            new_reg        <= '0;
            fin_reg        <= 1'b0;
            count_reg      <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            drop_reg       <= 1'b0;
            cur_end_reg    <= '0;
            best_valid_reg <= 1'b0;
            best_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            new_reg        <= new_next;
            fin_reg        <= fin_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            drop_reg       <= drop_next;
            cur_end_reg    <= cur_end_next;
            best_valid_reg <= best_valid_next;
            best_reg       <= best_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(out_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RANGES))
        else $error("range count above capacity");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending selection left behind in idle");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("output request overwritten");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (i_reg < count_reg))
        else $error("scan index past stored ranges");

    a_scan_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_free && !best_valid_reg |=> s_tready)
        else $error("set not cleared after flush");
`endif

endmodule

>>> rtl/gic_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_store: sorted range store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module gic_store import gic_pkg::*; #(
    parameter int DEPTH = GIC_MAX_RANGES,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  gic_entry_t    wr_data,
    input  logic [AW-1:0] rd_addr,
    output gic_entry_t    rd_data
);

    gic_entry_t mem [DEPTH];
    gic_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/gic_cover_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_cover_checker: scoreboard for the greedy interval cover unit
// Watches both stream channels, predicts the chosen ranges of every set and
// compares each output request with the oldest prediction.
// ----------------------------------------------------------------------------
module gic_cover_checker import gic_pkg::*; #(
    parameter int MAX_RANGES = GIC_MAX_RANGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] range_start, [31:16] range_end
    input  logic        s_tlast,   // final_range
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [15:0] chosen_start, [31:16] chosen_end
    input  logic        m_tlast,   // chosen_last
    input  logic        m_tuser,   // [0] overflowed
    output int          fail_count,
    output int          pending
);

    localparam int NO_PICK = -1;

    typedef struct packed {
        gic_entry_t span;
        logic       last;
        logic       ovf;
    } cover_pick_t;

    gic_entry_t  range_store [MAX_RANGES];
    int          range_cnt;
    logic        dropped;
    cover_pick_t expected_picks [$];
    int          err_total;

    // Insert one range, keeping ascending start and larger end first.
    task automatic absorb_range(input gic_entry_t r);
        int pos;
        pos = 0;
        while (pos < range_cnt &&
               !((r.lo < range_store[pos].lo) ||
                 (r.lo == range_store[pos].lo && r.hi > range_store[pos].hi)))
            pos++;
        for (int k = range_cnt; k > pos; k--)
            range_store[k] = range_store[k-1];
        range_store[pos] = r;
        range_cnt++;
    endtask

    // Greedy scan over the sorted store; appends the chosen ranges in order.
    task automatic scan_cover();
        cover_pick_t picks [$];
        cover_pick_t p;
        gic_coord_t  reach;
        int          best;
        int          i;
        if (range_cnt > 0)
        begin
            p = '{span: range_store[0], last: 1'b0, ovf: dropped};
            picks.insert(picks.size(), p);
            reach = range_store[0].hi;
            best  = NO_PICK;
            i     = 1;
            while (i < range_cnt)
            begin
                if (range_store[i].hi <= reach)
                begin
                    i++;
                    continue;
                end
                if (range_store[i].lo > reach)
                begin
                    if (best != NO_PICK)
                    begin
                        // gap ahead: commit the tracked range and retry entry i
                        p.span = range_store[best];
                        picks.insert(picks.size(), p);
                        reach = range_store[best].hi;
                        best  = NO_PICK;
                        continue;
                    end
                    p.span = range_store[i];
                    picks.insert(picks.size(), p);
                    reach = range_store[i].hi;
                end
                else if (best == NO_PICK || range_store[i].hi >= range_store[best].hi)
                    best = i;
                i++;
            end
            if (best != NO_PICK)
            begin
                p.span = range_store[best];
                picks.insert(picks.size(), p);
            end
            picks[picks.size()-1].last = 1'b1;
            foreach (picks[j])
                expected_picks.insert(expected_picks.size(), picks[j]);
        end
        range_cnt = 0;
        dropped   = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cover_pick_t got;
        cover_pick_t want;
        if (!rst_n)
        begin
            range_cnt  = 0;
            dropped    = 1'b0;
            err_total  = 0;
            expected_picks.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (range_cnt < MAX_RANGES)
                    absorb_range(gic_entry_t'(s_tdata));
                else
                    dropped = 1'b1;
                if (s_tlast)
                    scan_cover();
            end
            if (m_tvalid && m_tready)
            begin
                got = '{span: gic_entry_t'(m_tdata), last: m_tlast, ovf: m_tuser};
                if (expected_picks.size() == 0)
                begin
                    err_total++;
                    $display("%0t: unexpected request start=%0d end=%0d last=%0b ovf=%0b",
                             $time, got.span.lo, got.span.hi, got.last, got.ovf);
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (got !== want)
                    begin
                        err_total++;
                        $display("%0t: mismatch expected start=%0d end=%0d last=%0b ovf=%0b",
                                 $time, want.span.lo, want.span.hi, want.last, want.ovf);
                        $display("%0t:          actual   start=%0d end=%0d last=%0b ovf=%0b",
                                 $time, got.span.lo, got.span.hi, got.last, got.ovf);
                    end
                end
            end
            fail_count <= err_total;
            pending    <= expected_picks.size();
        end
    end

endmodule

>>> tb/greedy_interval_cover_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_interval_cover_unit_tb: top of the greedy interval cover testbench
// Feeds directed and random range sets through the unit, with random idle
// cycles on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module greedy_interval_cover_unit_tb;
    import gic_pkg::*;

    // coordinate styles for a random set
    typedef enum int {
        COORD_DENSE,    // short ranges packed into a small window, lots of overlap
        COORD_FULL,     // any 16-bit value for both ends
        COORD_TOP,      // crowded against the top of the coordinate space
        COORD_TANGLED   // small window, end may sit below start
    } coord_style_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] range_start, [31:16] range_end
    logic        s_tlast  = 1'b0; // final_range
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [15:0] chosen_start, [31:16] chosen_end
    logic        m_tlast;         // chosen_last
    logic        m_tuser;         // [0] overflowed

    int          fail_count;
    int          pending;

    // set while both sides must run without any idle cycle
    bit          steady = 1'b0;
    int          random_sent;

    greedy_interval_cover_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    gic_cover_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Output side backpressure: ~12% stall, none during the steady stretch.
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 12);
    end

    // One range request. s_tvalid stays high into the next call unless an
    // idle gap is taken, so it never gets two updates in one step.
    task automatic send_range(input gic_coord_t lo, input gic_coord_t hi,
                              input logic last);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 12)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // A full set of random ranges, closed by a final range.
    task automatic send_random_set(input int count, input coord_style_t style);
        gic_coord_t lo;
        gic_coord_t hi;
        for (int n = 0; n < count; n++)
        begin
            case (style)
                COORD_DENSE:
                begin
                    lo = gic_coord_t'($urandom_range(0, 40));
                    hi = lo + gic_coord_t'($urandom_range(0, 15));
                end
                COORD_FULL:
                begin
                    lo = gic_coord_t'($urandom);
                    hi = gic_coord_t'($urandom);
                end
                COORD_TOP:
                begin
                    lo = gic_coord_t'($urandom_range(65500, 65535));
                    hi = gic_coord_t'($urandom_range(32'(lo), 65535));
                end
                default:
                begin
                    lo = gic_coord_t'($urandom_range(0, 60));
                    hi = gic_coord_t'($urandom_range(0, 60));
                end
            endcase
            // the long no-idle stretch covers random items 150 to 259
            steady = (random_sent >= 150 && random_sent < 260);
            send_range(lo, hi, n == count - 1);
            random_sent++;
        end
    endtask

    initial
    begin
        int           set_size;
        coord_style_t style;

        random_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed sets ----
        // single range at the bottom and at the top of the space
        send_range(16'd0, 16'd0, 1'b1);
        send_range(16'hFFFF, 16'hFFFF, 1'b1);
        // widest range plus a point at the top; sort puts the wide one first
        send_range(16'hFFFF, 16'hFFFF, 1'b0);
        send_range(16'd0, 16'hFFFF, 1'b1);
        // mixed order, a contained range and a disjoint tail
        send_range(16'd5, 16'd10, 1'b0);
        send_range(16'd0, 16'd3, 1'b0);
        send_range(16'd2, 16'd8, 1'b0);
        send_range(16'd5, 16'd12, 1'b0);
        send_range(16'd20, 16'd25, 1'b1);
        // end below start is taken as is
        send_range(16'd100, 16'd50, 1'b0);
        send_range(16'd40, 16'd60, 1'b1);
        // identical ranges
        send_range(16'd7, 16'd9, 1'b0);
        send_range(16'd7, 16'd9, 1'b0);
        send_range(16'd7, 16'd9, 1'b1);
        // chain of overlaps: tracked best range is committed at the gap
        send_range(16'd0, 16'd10, 1'b0);
        send_range(16'd5, 16'd20, 1'b0);
        send_range(16'd8, 16'd30, 1'b0);
        send_range(16'd25, 16'd40, 1'b0);
        send_range(16'd50, 16'd60, 1'b1);

        // ---- random sets ----
        // store exactly full, then overflowing on ordinary and final ranges
        send_random_set(GIC_MAX_RANGES, COORD_DENSE);
        send_random_set(GIC_MAX_RANGES + 4, COORD_TANGLED);
        while (random_sent < 410)
        begin
            if ($urandom_range(0, 99) < 8)
                set_size = $urandom_range(13, 30);
            else
                set_size = $urandom_range(1, 12);
            style = coord_style_t'($urandom_range(0, 3));
            send_random_set(set_size, style);
        end
        s_tvalid <= 1'b0;
        steady   = 1'b0;

        // drain: let the checker log the last set, wait until all predictions
        // are consumed, then a margin for stray requests
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
